/* rtl/ldnd_pkg.sv */
package ldnd_pkg;

	localparam int SAMPLE_W = 10;
	localparam int ACC_W    = 12;
	localparam int LEVEL_W  = 10;
	localparam int PHASE_W  = 2;
	localparam int REG_IDX_W = 2;

	localparam logic [ACC_W-1:0] ACC_RESET = 12'd600;
	localparam logic [SAMPLE_W-1:0] DAY_THRESHOLD_RESET = 10'd160;
	localparam logic [SAMPLE_W-1:0] DAY_HYSTERESIS_RESET = 10'd20;

	localparam logic [REG_IDX_W-1:0] REG_DAY_THRESHOLD       = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DAY_HYSTERESIS      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHARGE_FORCES_NIGHT = 2'd2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [ACC_W-1:0] acc_t;

	// Leak a quarter of the accumulator, then add one sample.
	function automatic acc_t leak_add(input acc_t acc, input sample_t sample);
		logic [ACC_W:0] sum;
		begin
			sum = {1'b0, acc - {2'b00, acc[ACC_W-1:2]}} + {{(ACC_W+1-SAMPLE_W){1'b0}}, sample};
			leak_add = sum[ACC_W-1:0];
		end
	endfunction

endpackage

/* rtl/light_day_night_detector.sv */
// A beat accepted from the poll channel sits in the input register, and its result is loaded into
// the result register when that register is empty or being drained.
// One poll per cycle while in_stall is low; the detector state updates as each beat leaves stage 1.
// Reset (arst_n low, asynchronous): accumulator 600, warm-up phase init, night set,
// threshold 160, hysteresis 20, charge override off, both pipeline registers empty.
module light_day_night_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_write_en,
	input  logic [ldnd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [ldnd_pkg::SAMPLE_W-1:0]  cfg_data,
	// poll input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ldnd_pkg::SAMPLE_W-1:0]  sample_a,
	input  logic [ldnd_pkg::SAMPLE_W-1:0]  sample_b,
	input  logic [ldnd_pkg::SAMPLE_W-1:0]  sample_c,
	input  logic [ldnd_pkg::SAMPLE_W-1:0]  sample_d,
	input  logic                          charging,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          night,
	output logic [ldnd_pkg::LEVEL_W-1:0]   light_level
);
	import ldnd_pkg::*;

	// warm-up phase codes; the unused code behaves as ready
	localparam logic [PHASE_W-1:0] PHASE_INIT      = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_DECREASED = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_READY     = 2'd2;

	// configuration registers
	logic [SAMPLE_W-1:0] day_threshold_q;
	logic [SAMPLE_W-1:0] day_hysteresis_q;
	logic                charge_forces_night_q;

	// detector state
	acc_t               acc_q;
	logic [PHASE_W-1:0] phase_q;
	logic               night_q;

	// input register (stage 1)
	logic    valid_s1;
	sample_t sample_a_s1, sample_b_s1, sample_c_s1, sample_d_s1;
	logic    charging_s1;

	// result register (stage 2)
	logic               valid_s2;
	logic               night_s2;
	logic [LEVEL_W-1:0] level_s2;

	// next-state logic
	logic               advance;
	logic               forced;
	acc_t               acc_next;
	logic [PHASE_W-1:0] phase_next;
	logic               night_next;
	logic [LEVEL_W-1:0] level_new;
	logic [SAMPLE_W:0]  day_upper;

	// Move the stage-1 beat into the result register whenever that register is free or
	// being drained this cycle; take a new beat whenever stage 1 is empty or moving.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign forced    = charge_forces_night_q && charging_s1;
	assign day_upper = {1'b0, day_threshold_q} + {1'b0, day_hysteresis_q};

	always_comb begin
		acc_next   = acc_q;
		phase_next = phase_q;
		night_next = night_q;
		level_new  = '0;
		if (forced) begin
			// hold level and warm-up, force night
			night_next = 1'b1;
		end else begin
			// four leaky updates in sample order
			acc_next  = leak_add(leak_add(leak_add(leak_add(acc_q, sample_a_s1),
				sample_b_s1), sample_c_s1), sample_d_s1);
			level_new = acc_next[ACC_W-1:2];
			if (!phase_q[1]) begin
				// warming up: wait for a fall, then a rise
				if (acc_next < acc_q)
					phase_next = PHASE_DECREASED;
				if (acc_next > acc_q && phase_q == PHASE_DECREASED)
					phase_next = PHASE_READY;
			end else begin
				// hysteresis: clear above upper bound, set below threshold
				if (night_next && {1'b0, level_new} > day_upper)
					night_next = 1'b0;
				if (!night_next && level_new < day_threshold_q)
					night_next = 1'b1;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_threshold_q       <= DAY_THRESHOLD_RESET;
			day_hysteresis_q      <= DAY_HYSTERESIS_RESET;
			charge_forces_night_q <= 1'b0;
		end else if (cfg_write_en) begin
			if (cfg_index == REG_DAY_THRESHOLD)
				day_threshold_q <= cfg_data;
			if (cfg_index == REG_DAY_HYSTERESIS)
				day_hysteresis_q <= cfg_data;
			if (cfg_index == REG_CHARGE_FORCES_NIGHT)
				charge_forces_night_q <= cfg_data[0];
		end
	end

	// detector state advances once per beat leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= ACC_RESET;
			phase_q <= PHASE_INIT;
			night_q <= 1'b1;
		end else if (advance) begin
			acc_q   <= acc_next;
			phase_q <= phase_next;
			night_q <= night_next;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload: load on accept only
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_a_s1 <= sample_a;
			sample_b_s1 <= sample_b;
			sample_c_s1 <= sample_c;
			sample_d_s1 <= sample_d;
			charging_s1 <= charging;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// stage 2 payload; a forced beat reports the held level
	always_ff @(posedge clk) begin
		if (advance) begin
			night_s2 <= night_next;
			level_s2 <= acc_next[ACC_W-1:2];
		end
	end

	assign out_valid   = valid_s2;
	assign night       = night_s2;
	assign light_level = level_s2;

	// once ready, the warm-up never restarts
	a_ready_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PHASE_READY |=> phase_q == PHASE_READY)
		else $error("warm-up phase left ready");

	// state moves only with a beat leaving stage 1
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(acc_q) && $stable(phase_q) && $stable(night_q))
		else $error("detector state changed without a beat");

	// forced night keeps level and warm-up
	a_forced_night: assert property (@(posedge clk) disable iff (!arst_n)
		advance && forced |=> night_q && $stable(acc_q) && $stable(phase_q))
		else $error("forced night disturbed level or warm-up");

	// no decision during warm-up
	a_warmup_no_decision: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (phase_q == PHASE_INIT || phase_q == PHASE_DECREASED) && !forced
		|=> $stable(night_q))
		else $error("night flag changed during warm-up");

	// result register reports the state just committed
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> night_s2 == night_q && level_s2 == acc_q[ACC_W-1:2])
		else $error("result does not match detector state");

endmodule
